>>> rtl/gaussian_kl_divergence_accumulator_top_macros.svh
// assertion macros for the kl divergence accumulator top level
// expects clk and arst_n in the scope where a macro is used
`ifndef GAUSSIAN_KL_DIVERGENCE_ACCUMULATOR_TOP_MACROS_SVH
`define GAUSSIAN_KL_DIVERGENCE_ACCUMULATOR_TOP_MACROS_SVH

// same-cycle implication
`define GKLD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gkld: same-cycle check failed");

// next-cycle implication
`define GKLD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gkld: next-cycle check failed");

`endif

>>> rtl/gkld_pkg.sv
// shared types, constants and saturating add for the kl divergence accumulator
// no dependencies
package gkld_pkg;

	typedef enum logic [1:0] {
		MODE_FULL   = 2'd0,
		MODE_MEAN   = 2'd1,
		MODE_COV    = 2'd2,
		MODE_WEIGHT = 2'd3
	} mode_t;

	// what the back end has to compute for one request
	typedef enum logic [2:0] {
		KIND_ZERO,
		KIND_NONE,
		KIND_MEAN,
		KIND_COV,
		KIND_BOTH,
		KIND_WEIGHT
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		mode_t              mode;
		logic               last;
		logic signed [31:0] mean_src;
		logic signed [31:0] mean_upd;
		logic [31:0]        var_src;
		logic [31:0]        var_upd;
		logic [16:0]        weight_src;
		logic [16:0]        weight_upd;
	} entry_t;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_ZERO = 2'd1;
	localparam logic [1:0] STATUS_SAT  = 2'd2;

	localparam int FLAG_ZERO = 0;
	localparam int FLAG_SAT  = 1;

	localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [47:0] OUT_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] OUT_MIN = 48'sh8000_0000_0000;

	// ln(2) in q0.16
	localparam logic [15:0] LN2_Q16 = 16'd45426;

	typedef struct packed {
		logic signed [63:0] val;
		logic               ovf;
	} sat_t;

	function automatic sat_t sat_add(input logic signed [63:0] a, input logic signed [63:0] b);
		sat_t               r;
		logic signed [63:0] s;
		s     = a + b;
		r.ovf = (a[63] == b[63]) && (s[63] != a[63]);
		r.val = r.ovf ? (a[63] ? SUM_MIN : SUM_MAX) : s;
		return r;
	endfunction

endpackage

>>> rtl/gkld_chan_if.sv
// valid/ready channels for input requests and results
// no dependencies
interface gkld_item_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] mean_src;
	logic signed [31:0] mean_upd;
	logic [31:0]        var_src;
	logic [31:0]        var_upd;
	logic [16:0]        weight_src;
	logic [16:0]        weight_upd;
	logic               last_element;

	modport source(output valid, mean_src, mean_upd, var_src, var_upd, weight_src,
		weight_upd, last_element, input ready);
	modport sink(input valid, mean_src, mean_upd, var_src, var_upd, weight_src,
		weight_upd, last_element, output ready);
endinterface

interface gkld_result_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] divergence;
	logic [1:0]         status;

	modport source(output valid, divergence, status, input ready);
	modport sink(input valid, divergence, status, output ready);
endinterface

>>> rtl/gaussian_kl_divergence_accumulator_top.sv
// kl divergence accumulator top: mode register, front end, queue, back end
// depends on gkld_pkg, gkld_chan_if, gkld_front, gkld_fifo, gkld_back
// the back end takes one request at a time from the queue, so its pace is set by
// the bit-serial divider and log unit; the result is registered in the closing
// state once the output register is free; arst_n clears mode, sum, count, flags
// and all valids at once
module gaussian_kl_divergence_accumulator_top import gkld_pkg::*; #(
	parameter int MAX_DIM = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_data,
	gkld_item_if.sink  item,
	gkld_result_if.source result
);

	mode_t  mode_q;
	logic   fifo_push;
	entry_t fifo_wdata;
	logic   fifo_full;
	logic   fifo_pop;
	logic   fifo_valid;
	entry_t fifo_rdata;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= MODE_FULL;
		else if (cfg_we)
			mode_q <= mode_t'(cfg_data);
	end

	gkld_front u_front (
		.item      (item),
		.mode      (mode_q),
		.fifo_full (fifo_full),
		.push      (fifo_push),
		.push_data (fifo_wdata)
	);

	gkld_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_data (fifo_wdata),
		.full      (fifo_full),
		.pop       (fifo_pop),
		.pop_valid (fifo_valid),
		.pop_data  (fifo_rdata)
	);

	gkld_back #(
		.MAX_DIM (MAX_DIM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (fifo_valid),
		.pop_data  (fifo_rdata),
		.pop       (fifo_pop),
		.result    (result)
	);

`include "gaussian_kl_divergence_accumulator_top_macros.svh"

	// queue checks
	`GKLD_ASSERT_IMP(a_push_not_full, fifo_push, !fifo_full)
	`GKLD_ASSERT_IMP(a_pop_has_data, fifo_pop, fifo_valid)
	`GKLD_ASSERT_NXT(a_push_fills, fifo_push && !fifo_pop, fifo_valid)

endmodule

>>> rtl/gkld_front.sv
// front end: accepts requests and classifies the work each one needs
// depends on gkld_pkg and gkld_item_if
module gkld_front import gkld_pkg::*; (
	gkld_item_if.sink item,
	input  mode_t     mode,
	input  logic      fifo_full,
	output logic      push,
	output entry_t    push_data
);

	// accept whenever the queue has room
	assign item.ready = !fifo_full;
	assign push       = item.valid && !fifo_full;

	// classify by mode and zero operands
	always_comb begin
		push_data.mode       = mode;
		push_data.last       = item.last_element;
		push_data.mean_src   = item.mean_src;
		push_data.mean_upd   = item.mean_upd;
		push_data.var_src    = item.var_src;
		push_data.var_upd    = item.var_upd;
		push_data.weight_src = item.weight_src;
		push_data.weight_upd = item.weight_upd;
		unique case (mode)
			MODE_FULL: begin
				push_data.kind = (item.var_src == '0 || item.var_upd == '0) ? KIND_ZERO : KIND_BOTH;
			end
			MODE_MEAN: begin
				push_data.kind = (item.var_src == '0) ? KIND_ZERO : KIND_MEAN;
			end
			MODE_COV: begin
				push_data.kind = (item.var_src == '0 || item.var_upd == '0) ? KIND_ZERO : KIND_COV;
			end
			default: begin
				// zero target weight contributes nothing, without a flag
				if (item.weight_upd == '0)
					push_data.kind = KIND_NONE;
				else if (item.weight_src == '0)
					push_data.kind = KIND_ZERO;
				else
					push_data.kind = KIND_WEIGHT;
			end
		endcase
	end

endmodule

>>> rtl/gkld_fifo.sv
// two-entry queue between front and back end
// depends on gkld_pkg
module gkld_fifo import gkld_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	input  logic   pop,
	output logic   pop_valid,
	output entry_t pop_data
);

	entry_t     mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_data  = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/gkld_div.sv
// restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle
// no dependencies
module gkld_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  step_q;
	logic [31:0] rem_q;
	logic [31:0] dsr_q;
	logic [63:0] quo_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        ge;

	// one trial subtraction
	assign trial = {rem_q, quo_q[63]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = (trial >= {1'b0, dsr_q});

	assign done     = done_q;
	assign quotient = quo_q;

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && busy_q && (step_q == 6'd63);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 6'd1;
				if (step_q == 6'd63)
					busy_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/gkld_ln.sv
// natural log of a nonzero 32-bit integer, q5.16, floored
// normalize one bit a cycle, then 16 squaring steps; depends on gkld_pkg
module gkld_ln import gkld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] x,
	output logic        done,
	output logic [20:0] ln_val
);

	typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ, L_SCALE} lstate_t;

	lstate_t     st_q;
	logic [31:0] m_q;
	logic [4:0]  k_q;
	logic [15:0] frac_q;
	logic [3:0]  it_q;
	logic        done_q;
	logic [20:0] res_q;
	logic [63:0] sq;
	logic [32:0] p;
	logic [36:0] scaled;

	// mantissa squared, back to q2.31 (range up to 4.0)
	assign sq     = 64'(m_q) * 64'(m_q);
	assign p      = sq[63:31];
	assign scaled = 37'({k_q, frac_q}) * 37'(LN2_Q16);

	assign done   = done_q;
	assign ln_val = res_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= L_IDLE;
			m_q    <= '0;
			k_q    <= '0;
			frac_q <= '0;
			it_q   <= '0;
			done_q <= 1'b0;
			res_q  <= '0;
		end else begin
			done_q <= (st_q == L_SCALE);
			unique case (st_q)
				L_IDLE: begin
					if (start) begin
						m_q    <= x;
						k_q    <= 5'd31;
						frac_q <= '0;
						it_q   <= '0;
						st_q   <= L_NORM;
					end
				end
				L_NORM: begin
					if (m_q[31]) begin
						st_q <= L_SQ;
					end else begin
						m_q <= {m_q[30:0], 1'b0};
						k_q <= k_q - 5'd1;
					end
				end
				L_SQ: begin
					frac_q <= {frac_q[14:0], p[32]};
					m_q    <= p[32] ? p[32:1] : p[31:0];
					it_q   <= it_q + 4'd1;
					if (it_q == 4'd15)
						st_q <= L_SCALE;
				end
				default: begin
					res_q <= scaled[36:16];
					st_q  <= L_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/gkld_back.sv
// back end: computes each term, accumulates and forms the result
// depends on gkld_pkg, gkld_result_if, gkld_div and gkld_ln
module gkld_back import gkld_pkg::*; #(
	parameter int MAX_DIM = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	input  entry_t     pop_data,
	output logic       pop,
	gkld_result_if.source result
);

	localparam int CNT_W = $clog2(MAX_DIM + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_ABS, S_MUL, S_DIVM, S_DIVC, S_LNA, S_LNB, S_COMB, S_WMUL, S_ACC, S_FIN
	} state_t;

	state_t             st_q;
	entry_t             ent_q;
	logic [31:0]        ad_q;
	logic [63:0]        sq_q;
	logic signed [63:0] mean_q;
	logic [47:0]        ratio_q;
	logic [20:0]        lna_q;
	logic [20:0]        lnb_q;
	logic signed [63:0] term_q;
	logic signed [63:0] sum_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [1:0]         flags_q;
	logic               div_start_q;
	logic               ln_start_q;
	logic               out_valid_q;
	logic signed [47:0] out_div_q;
	logic [1:0]         out_status_q;

	logic               div_done;
	logic [63:0]        div_quo;
	logic [63:0]        div_dividend;
	logic               ln_done;
	logic [20:0]        ln_res;
	logic [31:0]        ln_x;
	logic signed [32:0] d;
	logic signed [32:0] nd;
	logic [31:0]        abs_d;
	logic signed [63:0] mean_val;
	logic signed [63:0] cov_val;
	sat_t               both_sum;
	logic signed [21:0] ln_diff;
	logic signed [39:0] wprod;
	sat_t               acc_sum;
	logic               cnt_full;
	logic signed [63:0] cnt_ext;
	sat_t               adj;
	logic signed [63:0] pre;
	logic               adj_ovf;
	logic               ovf48;
	logic signed [47:0] res48;
	logic [1:0]         fin_flags;
	logic [1:0]         fin_status;
	logic               is_weight;
	logic               fin_ok;

	gkld_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_dividend),
		.divisor  (ent_q.var_src),
		.done     (div_done),
		.quotient (div_quo)
	);

	gkld_ln u_ln (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ln_start_q),
		.x      (ln_x),
		.done   (ln_done),
		.ln_val (ln_res)
	);

	assign is_weight = (ent_q.kind == KIND_WEIGHT);

	// operand selection for the shared units
	assign div_dividend = (st_q == S_DIVC) ? {16'b0, ent_q.var_upd, 16'b0} : sq_q;
	always_comb begin
		if (st_q == S_LNA)
			ln_x = is_weight ? {15'b0, ent_q.weight_upd} : ent_q.var_src;
		else
			ln_x = is_weight ? {15'b0, ent_q.weight_src} : ent_q.var_upd;
	end

	// mean difference magnitude
	assign d     = {ent_q.mean_upd[31], ent_q.mean_upd} - {ent_q.mean_src[31], ent_q.mean_src};
	assign nd    = -d;
	assign abs_d = d[32] ? nd[31:0] : d[31:0];

	// quotient above the signed range clamps
	assign mean_val = div_quo[63] ? SUM_MAX : $signed(div_quo);

	// covariance term: ratio plus log ratio
	assign cov_val  = $signed({16'b0, ratio_q}) + $signed({43'b0, lna_q})
		- $signed({43'b0, lnb_q});
	assign both_sum = sat_add(mean_q, cov_val);

	// weight term: w_upd times log ratio, floored to q16.16
	assign ln_diff = $signed({1'b0, lna_q}) - $signed({1'b0, lnb_q});
	assign wprod   = $signed({1'b0, ent_q.weight_upd}) * ln_diff;

	// accumulate
	assign acc_sum  = sat_add(sum_q, term_q);
	assign cnt_full = (cnt_q >= CNT_W'(MAX_DIM));

	// final result
	assign cnt_ext = $signed(64'({cnt_q, 16'b0}));
	assign adj     = sat_add(sum_q, -cnt_ext);
	always_comb begin
		adj_ovf = 1'b0;
		unique case (ent_q.mode)
			MODE_FULL, MODE_COV: begin
				pre     = adj.val >>> 1;
				adj_ovf = adj.ovf;
			end
			MODE_MEAN: pre = sum_q >>> 1;
			default:   pre = sum_q;
		endcase
	end
	assign ovf48      = !((&pre[63:47]) || !(|pre[63:47]));
	assign res48      = ovf48 ? (pre[63] ? OUT_MIN : OUT_MAX) : pre[47:0];
	assign fin_flags  = flags_q | {ovf48 | adj_ovf, 1'b0};
	assign fin_status = fin_flags[FLAG_ZERO] ? STATUS_ZERO
		: (fin_flags[FLAG_SAT] ? STATUS_SAT : STATUS_OK);
	assign fin_ok     = !out_valid_q || result.ready;

	assign pop               = (st_q == S_IDLE) && pop_valid;
	assign result.valid      = out_valid_q;
	assign result.divergence = out_div_q;
	assign result.status     = out_status_q;

	// sequencer, accumulator and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			ent_q        <= '0;
			ad_q         <= '0;
			sq_q         <= '0;
			mean_q       <= '0;
			ratio_q      <= '0;
			lna_q        <= '0;
			lnb_q        <= '0;
			term_q       <= '0;
			sum_q        <= '0;
			cnt_q        <= '0;
			flags_q      <= '0;
			div_start_q  <= 1'b0;
			ln_start_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			out_div_q    <= '0;
			out_status_q <= STATUS_OK;
		end else begin
			// one-cycle start pulses for the shared units
			div_start_q <= (st_q == S_IDLE && pop_valid && pop_data.kind == KIND_COV)
				|| (st_q == S_MUL)
				|| (st_q == S_DIVM && div_done && ent_q.kind != KIND_MEAN);
			ln_start_q  <= (st_q == S_IDLE && pop_valid && pop_data.kind == KIND_WEIGHT)
				|| (st_q == S_DIVC && div_done)
				|| (st_q == S_LNA && ln_done);
			// result valid set on the closing cycle, cleared once taken
			if (st_q == S_FIN && fin_ok)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (pop_valid) begin
						ent_q <= pop_data;
						unique case (pop_data.kind)
							KIND_ZERO: begin
								flags_q[FLAG_ZERO] <= 1'b1;
								term_q             <= '0;
								st_q               <= S_ACC;
							end
							KIND_NONE: begin
								term_q <= '0;
								st_q   <= S_ACC;
							end
							KIND_MEAN, KIND_BOTH: st_q <= S_ABS;
							KIND_COV:             st_q <= S_DIVC;
							default:              st_q <= S_LNA;
						endcase
					end
				end
				S_ABS: begin
					ad_q <= abs_d;
					st_q <= S_MUL;
				end
				S_MUL: begin
					sq_q <= 64'(ad_q) * 64'(ad_q);
					st_q <= S_DIVM;
				end
				S_DIVM: begin
					if (div_done) begin
						if (div_quo[63])
							flags_q[FLAG_SAT] <= 1'b1;
						if (ent_q.kind == KIND_MEAN) begin
							term_q <= mean_val;
							st_q   <= S_ACC;
						end else begin
							mean_q <= mean_val;
							st_q   <= S_DIVC;
						end
					end
				end
				S_DIVC: begin
					if (div_done) begin
						ratio_q <= div_quo[47:0];
						st_q    <= S_LNA;
					end
				end
				S_LNA: begin
					if (ln_done) begin
						lna_q <= ln_res;
						st_q  <= S_LNB;
					end
				end
				S_LNB: begin
					if (ln_done) begin
						lnb_q <= ln_res;
						st_q  <= is_weight ? S_WMUL : S_COMB;
					end
				end
				S_COMB: begin
					if (ent_q.kind == KIND_BOTH) begin
						term_q <= both_sum.val;
						if (both_sum.ovf)
							flags_q[FLAG_SAT] <= 1'b1;
					end else begin
						term_q <= cov_val;
					end
					st_q <= S_ACC;
				end
				S_WMUL: begin
					term_q <= {{40{wprod[39]}}, wprod[39:16]};
					st_q   <= S_ACC;
				end
				S_ACC: begin
					sum_q <= acc_sum.val;
					if (acc_sum.ovf || cnt_full)
						flags_q[FLAG_SAT] <= 1'b1;
					if (!cnt_full)
						cnt_q <= cnt_q + CNT_W'(1);
					st_q <= ent_q.last ? S_FIN : S_IDLE;
				end
				default: begin
					if (fin_ok) begin
						out_div_q    <= res48;
						out_status_q <= fin_status;
						sum_q        <= '0;
						cnt_q        <= '0;
						flags_q      <= '0;
						st_q         <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule

>>> tb/gkld_checker.sv
// checker for the kl divergence accumulator: follows mode writes and accepted
// requests, predicts each divergence and compares the results in order
// depends on gkld_pkg and the channel interfaces in gkld_chan_if
module gkld_checker import gkld_pkg::*; #(
	parameter int MAX_DIM = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_data,
	gkld_item_if       item,
	gkld_result_if     result,
	output int         errors,
	output int         pending
);

	mode_t              cur_mode;
	logic signed [63:0] kl_sum;
	int unsigned        dim_count;
	logic [1:0]         err_flags;
	logic signed [47:0] div_expect[$];
	logic [1:0]         status_expect[$];

	// clamping 64-bit add that records saturation
	function automatic logic signed [63:0] clamp_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if ((a[63] == b[63]) && (s[63] != a[63])) begin
			err_flags[FLAG_SAT] = 1'b1;
			return a[63] ? SUM_MIN : SUM_MAX;
		end
		return s;
	endfunction

	// natural log of a nonzero integer in q16.16, floored
	function automatic logic [63:0] ln_fixed(input logic [63:0] x);
		int unsigned k;
		logic [63:0] m;
		logic [63:0] frac;
		k = 0;
		frac = 0;
		while (k < 63 && (x >> (k + 1)) != 0)
			k++;
		m = (k <= 31) ? (x << (31 - k)) : (x >> (k - 31));
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				frac = frac | 64'd1;
				m = m >> 1;
			end
		end
		return (((64'(k) << 16) | frac) * 64'd45426) >> 16;
	endfunction

	// squared mean difference over the source variance
	function automatic logic signed [63:0] mean_part(input logic [31:0] ms,
		input logic [31:0] mu, input logic [31:0] vs);
		logic signed [63:0] d;
		logic [63:0]        ad;
		logic [63:0]        q;
		d = $signed({{32{mu[31]}}, mu}) - $signed({{32{ms[31]}}, ms});
		ad = d[63] ? -d : d;
		q = (ad * ad) / {32'd0, vs};
		if (q[63]) begin
			err_flags[FLAG_SAT] = 1'b1;
			return SUM_MAX;
		end
		return $signed(q);
	endfunction

	// variance ratio plus log ratio
	function automatic logic signed [63:0] cov_part(input logic [31:0] vs, input logic [31:0] vu);
		logic [63:0] ratio;
		ratio = ({32'd0, vu} << 16) / {32'd0, vs};
		return $signed(ratio) + $signed(ln_fixed({32'd0, vs})) - $signed(ln_fixed({32'd0, vu}));
	endfunction

	// one accepted request: add its term, close the vector on last
	task automatic absorb_request(input logic [31:0] ms, input logic [31:0] mu,
		input logic [31:0] vs, input logic [31:0] vu, input logic [16:0] ws,
		input logic [16:0] wu, input logic last);
		logic signed [63:0] term;
		logic signed [63:0] res;
		logic signed [63:0] diff;
		term = 0;
		case (cur_mode)
			MODE_FULL: begin
				if (vs == 0 || vu == 0) err_flags[FLAG_ZERO] = 1'b1;
				else term = clamp_add(mean_part(ms, mu, vs), cov_part(vs, vu));
			end
			MODE_MEAN: begin
				if (vs == 0) err_flags[FLAG_ZERO] = 1'b1;
				else term = mean_part(ms, mu, vs);
			end
			MODE_COV: begin
				if (vs == 0 || vu == 0) err_flags[FLAG_ZERO] = 1'b1;
				else term = cov_part(vs, vu);
			end
			default: begin
				if (wu == 0) term = 0;
				else if (ws == 0) err_flags[FLAG_ZERO] = 1'b1;
				else begin
					diff = $signed(ln_fixed({47'd0, wu})) - $signed(ln_fixed({47'd0, ws}));
					term = ($signed({47'd0, wu}) * diff) >>> 16;
				end
			end
		endcase
		kl_sum = clamp_add(kl_sum, term);
		if (dim_count < MAX_DIM) dim_count++;
		else err_flags[FLAG_SAT] = 1'b1;
		if (last) begin
			if (cur_mode == MODE_FULL || cur_mode == MODE_COV)
				res = clamp_add(kl_sum, -($signed(64'(dim_count)) <<< 16)) >>> 1;
			else if (cur_mode == MODE_MEAN)
				res = kl_sum >>> 1;
			else
				res = kl_sum;
			if (res > 64'sh0000_7FFF_FFFF_FFFF) begin
				res = 64'sh0000_7FFF_FFFF_FFFF;
				err_flags[FLAG_SAT] = 1'b1;
			end
			if (res < 64'shFFFF_8000_0000_0000) begin
				res = 64'shFFFF_8000_0000_0000;
				err_flags[FLAG_SAT] = 1'b1;
			end
			div_expect.push_back(res[47:0]);
			status_expect.push_back(err_flags[FLAG_ZERO] ? STATUS_ZERO :
				(err_flags[FLAG_SAT] ? STATUS_SAT : STATUS_OK));
			kl_sum = 0;
			dim_count = 0;
			err_flags = 0;
		end
	endtask

	// watch mode writes, requests and results
	always @(posedge clk or negedge arst_n) begin
		logic signed [47:0] exp_div;
		logic [1:0]         exp_status;
		if (!arst_n) begin
			cur_mode = MODE_FULL;
			kl_sum = 0;
			dim_count = 0;
			err_flags = 0;
			errors = 0;
			div_expect.delete();
			status_expect.delete();
		end else begin
			if (cfg_we) cur_mode = mode_t'(cfg_data);
			if (item.valid && item.ready)
				absorb_request(item.mean_src, item.mean_upd, item.var_src, item.var_upd,
					item.weight_src, item.weight_upd, item.last_element);
			if (result.valid && result.ready) begin
				if (div_expect.size() == 0) begin
					$display("%0t: unexpected result divergence %h status %0d", $time,
						result.divergence, result.status);
					errors++;
				end else begin
					exp_div = div_expect.pop_front();
					exp_status = status_expect.pop_front();
					if (result.divergence !== exp_div) begin
						$display("%0t: divergence expected %h actual %h", $time, exp_div,
							result.divergence);
						errors++;
					end
					if (result.status !== exp_status) begin
						$display("%0t: status expected %0d actual %0d", $time, exp_status,
							result.status);
						errors++;
					end
				end
			end
		end
		pending = div_expect.size();
	end

endmodule

>>> tb/tb.sv
// testbench top for the kl divergence accumulator: clock, reset, mode writes,
// request and result traffic; depends on gkld_pkg, gkld_chan_if and gkld_checker
module tb import gkld_pkg::*;;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_data;
	int errors;
	int pending;
	bit quiet;
	bit stall_req;
	bit stall_done;
	int hold_left;

	gkld_item_if item_ch();
	gkld_result_if res_ch();

	gaussian_kl_divergence_accumulator_top #(.MAX_DIM(64)) uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.item(item_ch), .result(res_ch)
	);

	gkld_checker #(.MAX_DIM(64)) chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.item(item_ch), .result(res_ch), .errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// result side: random back-pressure and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_left <= 0;
			stall_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_ch.ready <= 1'b0;
		end else if (stall_req && !stall_done) begin
			stall_done <= 1'b1;
			hold_left <= 3000;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= quiet || ($urandom_range(99) >= 7);
		end
	end

	// one request, with an occasional gap before it
	task automatic send_req(input logic [31:0] ms, input logic [31:0] mu,
		input logic [31:0] vs, input logic [31:0] vu, input logic [16:0] ws,
		input logic [16:0] wu, input logic last);
		if (!quiet && $urandom_range(99) < 7) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.mean_src <= ms;
		item_ch.mean_upd <= mu;
		item_ch.var_src <= vs;
		item_ch.var_upd <= vu;
		item_ch.weight_src <= ws;
		item_ch.weight_upd <= wu;
		item_ch.last_element <= last;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
	endtask

	task automatic set_mode(input mode_t m);
		item_ch.valid <= 1'b0;
		cfg_we <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every divergence, then let a trailing term drain
	task automatic drain;
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_mean;
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return $urandom_range(524288) - 262144;
		endcase
	endfunction

	function automatic logic [31:0] rand_var;
		int r;
		r = $urandom_range(99);
		if (r < 5) return 0;
		if (r < 15) return $urandom;
		if (r < 25) return $urandom_range(1, 255);
		return $urandom_range(32'h4000, 32'h40000);
	endfunction

	function automatic logic [16:0] rand_weight;
		int r;
		r = $urandom_range(99);
		if (r < 5) return '0;
		if (r < 10) return 17'($urandom_range(131071));
		return 17'($urandom_range(1, 65536));
	endfunction

	task automatic rand_vector(input int len);
		for (int i = 0; i < len; i++)
			send_req(rand_mean(), rand_mean(), rand_var(), rand_var(), rand_weight(),
				rand_weight(), i == len - 1);
	endtask

	initial begin
		#40_000_000;
		$display("Mismatches found");
		$finish;
	end

	// stimulus
	initial begin
		int sent;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = MODE_FULL;
		quiet = 1'b0;
		stall_req = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.mean_src = 0;
		item_ch.mean_upd = 0;
		item_ch.var_src = 0;
		item_ch.var_upd = 0;
		item_ch.weight_src = 0;
		item_ch.weight_upd = 0;
		item_ch.last_element = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full mode: extreme means saturate, zero variances flag
		set_mode(MODE_FULL);
		send_req(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF, 17'd0, 17'd0, 1'b1);
		send_req(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 17'd1, 17'd1, 1'b0);
		send_req(32'h0, 32'h0, 32'h0, 32'h0001_0000, 17'd0, 17'd0, 1'b1);
		send_req(32'hFFFF_0000, 32'h0, 32'hFFFF_FFFF, 32'h0, 17'h1FFFF, 17'h1FFFF, 1'b1);
		send_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1, 17'd0, 17'd0, 1'b1);
		drain();
		// means only
		set_mode(MODE_MEAN);
		send_req(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'h0, 17'd0, 17'd0, 1'b0);
		send_req(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'h0, 17'd0, 17'd0, 1'b1);
		send_req(32'h0003_0000, 32'hFFFD_0000, 32'h0, 32'h0, 17'd0, 17'd0, 1'b1);
		send_req(32'h0003_0000, 32'hFFFD_0000, 32'h0002_0000, 32'h0, 17'd0, 17'd0, 1'b1);
		drain();
		// covariances only
		set_mode(MODE_COV);
		send_req(32'h0, 32'h0, 32'd1, 32'hFFFF_FFFF, 17'd0, 17'd0, 1'b1);
		send_req(32'h0, 32'h0, 32'hFFFF_FFFF, 32'd1, 17'd0, 17'd0, 1'b1);
		send_req(32'h0, 32'h0, 32'h0001_0000, 32'h0, 17'd0, 17'd0, 1'b1);
		drain();
		// mixture weights: zero update weight, zero source weight, oversized weights
		set_mode(MODE_WEIGHT);
		send_req(32'h0, 32'h0, 32'h0, 32'h0, 17'd100, 17'd0, 1'b1);
		send_req(32'h0, 32'h0, 32'h0, 32'h0, 17'd0, 17'd500, 1'b1);
		send_req(32'h0, 32'h0, 32'h0, 32'h0, 17'd65536, 17'd65536, 1'b1);
		send_req(32'h0, 32'h0, 32'h0, 32'h0, 17'd1, 17'h1FFFF, 1'b0);
		send_req(32'h0, 32'h0, 32'h0, 32'h0, 17'h1FFFF, 17'd1, 1'b1);
		drain();

		// random phases over all modes
		for (int p = 0; p < 10; p++) begin
			set_mode(p < 4 ? mode_t'(p) : mode_t'($urandom_range(3)));
			quiet = (p == 5);
			if (p == 6) begin
				// count runs past the dimension limit
				rand_vector(70);
			end else if (p == 7) begin
				// result side held off while fast requests fill the block
				set_mode(MODE_FULL);
				stall_req = 1'b1;
				for (int i = 0; i < 40; i++)
					send_req(rand_mean(), rand_mean(), 32'h0, rand_var(), rand_weight(),
						rand_weight(), 1'b1);
			end
			sent = 0;
			while (sent < 35) begin
				int len;
				len = ($urandom_range(9) == 0) ? 1 : $urandom_range(1, 8);
				rand_vector(len);
				sent += len;
			end
			drain();
		end

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/gkld_pkg.sv
rtl/gkld_chan_if.sv
rtl/gkld_front.sv
rtl/gkld_fifo.sv
rtl/gkld_div.sv
rtl/gkld_ln.sv
rtl/gkld_back.sv
rtl/gaussian_kl_divergence_accumulator_top.sv
tb/gkld_checker.sv
tb/tb.sv
